FILE: rtl/u2u8_pkg.sv
package u2u8_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int MAX_BYTES       = 6;
    localparam int CNT_W           = 3;

    localparam logic [7:0]  LEAD2     = 8'hC0;
    localparam logic [7:0]  LEAD3     = 8'hE0;
    localparam logic [7:0]  LEAD4     = 8'hF0;
    localparam logic [7:0]  CONT      = 8'h80;
    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [5:0]  HIGH_PREFIX = 6'b110110;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    // one queued item: its utf-8 bytes (first byte lowest) and byte count
    typedef struct packed {
        logic [MAX_BYTES*8-1:0] bytes;
        logic [CNT_W-1:0]       cnt;
        logic                   last;
    } entry_t;

    // three byte encoding, first byte in the low bits
    function automatic logic [23:0] enc3(input logic [15:0] v);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        b0 = LEAD3 | {4'b0000, v[15:12]};
        b1 = CONT | {2'b00, v[11:6]};
        b2 = CONT | {2'b00, v[5:0]};
        return {b2, b1, b0};
    endfunction

endpackage

FILE: rtl/u2u8_front.sv
module u2u8_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [15:0]      code_unit,
    input  logic             last_unit,
    output logic             push,
    output u2u8_pkg::entry_t entry
);
    import u2u8_pkg::*;

    logic       held_valid_reg;
    logic       held_valid_next;
    logic [9:0] held_bits_reg;
    logic [9:0] held_bits_next;

    logic        is_high;
    logic        is_low;
    logic [23:0] flush_bytes;
    logic [23:0] unit_bytes;
    logic [CNT_W-1:0] unit_cnt;
    logic        hold_unit;
    logic [20:0] pair_cp;
    logic [31:0] pair_bytes;

    always_comb
    begin
        is_high     = code_unit inside {[HIGH_FIRST:HIGH_LAST]};
        is_low      = code_unit inside {[LOW_FIRST:LOW_LAST]};
        flush_bytes = enc3({HIGH_PREFIX, held_bits_reg});
        pair_cp     = {1'b0, held_bits_reg, code_unit[9:0]} + SUPP_BASE;
        pair_bytes  = {CONT | {2'b00, pair_cp[5:0]},
                       CONT | {2'b00, pair_cp[11:6]},
                       CONT | {2'b00, pair_cp[17:12]},
                       LEAD4 | {5'b00000, pair_cp[20:18]}};
        hold_unit   = 1'b0;
        unit_bytes  = '0;
        unit_cnt    = '0;
        if (code_unit < ONE_BYTE_LIMIT)
        begin
            unit_bytes = {16'h0000, code_unit[7:0]};
            unit_cnt   = CNT_W'(1);
        end
        else if (code_unit < TWO_BYTE_LIMIT)
        begin
            unit_bytes = {8'h00, CONT | {2'b00, code_unit[5:0]},
                          LEAD2 | {3'b000, code_unit[10:6]}};
            unit_cnt   = CNT_W'(2);
        end
        else if (is_high && !last_unit)
        begin
            hold_unit = 1'b1;
        end
        else
        begin
            unit_bytes = enc3(code_unit);
            unit_cnt   = CNT_W'(3);
        end
    end

    always_comb
    begin
        entry.last = last_unit;
        if (held_valid_reg && is_low)
        begin
            entry.bytes = {16'h0000, pair_bytes};
            entry.cnt   = CNT_W'(4);
        end
        else if (held_valid_reg)
        begin
            // held surrogate goes out first, then the new unit
            entry.bytes = {unit_bytes, flush_bytes};
            entry.cnt   = unit_cnt + CNT_W'(3);
        end
        else
        begin
            entry.bytes = {24'h000000, unit_bytes};
            entry.cnt   = unit_cnt;
        end
        push = accept && (entry.cnt != '0);
    end

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (accept)
        begin
            if (!(held_valid_reg && is_low) && hold_unit)
            begin
                held_valid_next = 1'b1;
                held_bits_next  = code_unit[9:0];
            end
            else
            begin
                held_valid_next = 1'b0;
                held_bits_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

FILE: rtl/u2u8_queue.sv
// depth must be 2 or more
module u2u8_queue #(
    parameter int DEPTH = u2u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  u2u8_pkg::entry_t wr_entry,
    input  logic             pop,
    output u2u8_pkg::entry_t head,
    output logic             empty,
    output logic             full
);
    import u2u8_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_QW = $clog2(DEPTH + 1);

    entry_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_QW-1:0]   count_reg;
    logic [CNT_QW-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        empty       = (count_reg == '0);
        full        = (count_reg == CNT_QW'(DEPTH));
        do_push     = push && !full;
        do_pop      = pop && !empty;
        head        = slot_reg[rd_ptr_reg];
        wr_ptr_next = do_push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/u2u8_back.sv
module u2u8_back (
    input  logic             clk,
    input  logic             rst_n,
    input  u2u8_pkg::entry_t head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic             m_tlast,   // string_end
    output logic             m_tuser    // run_last
);
    import u2u8_pkg::*;

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic             run_last_reg;
    logic             run_last_next;
    logic             str_end_reg;
    logic             str_end_next;
    logic             load;
    logic             run_end;

    always_comb
    begin
        // output register frees up when empty or being taken this cycle
        load          = !empty && (!valid_reg || m_tready);
        run_end       = (idx_reg == (head.cnt - CNT_W'(1)));
        pop           = load && run_end;
        idx_next      = idx_reg;
        valid_next    = valid_reg;
        byte_next     = byte_reg;
        run_last_next = run_last_reg;
        str_end_next  = str_end_reg;
        if (load)
        begin
            valid_next    = 1'b1;
            byte_next     = head.bytes[idx_reg*8 +: 8];
            run_last_next = run_end;
            str_end_next  = run_end && head.last;
            idx_next      = run_end ? '0 : idx_reg + CNT_W'(1);
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        run_last_reg <= run_last_next;
        str_end_reg  <= str_end_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = str_end_reg;
    assign m_tuser  = run_last_reg;

endmodule

FILE: rtl/utf16_to_utf8_transcoder_top.sv
// utf-16 to utf-8 transcoder
// the first byte of an item goes through a queue slot and then the output byte register before m_tvalid
// throughput: one output byte per cycle while m_tready is high; an item yields 1 to 3
//   bytes typical, 4 for a pair, up to 6 on a flush, sent one by one on the byte-wide output
// a held high surrogate yields nothing until the next unit arrives
// reset: rst_n async active low, clears the held surrogate, the queue and the output
module utf16_to_utf8_transcoder_top #(
    parameter int QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // code_unit
    input  logic        s_tlast,   // last_unit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,   // string_end
    output logic        m_tuser    // run_last
);
    import u2u8_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;
    entry_t wr_entry;
    entry_t head;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    u2u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_unit (s_tdata),
        .last_unit (s_tlast),
        .push      (push),
        .entry     (wr_entry)
    );

    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    u2u8_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/u2u8_checker.sv
module u2u8_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled output item changed");

    // string end only on the closing byte of an item
    a_end_on_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("string end without run end");

    // a lead byte of a multi-byte sequence never closes an item
    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[7:6] != 2'b11)
        else $error("item closed on a lead byte");

    // no byte at or above 0xf8 is ever produced
    a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:3] != 5'b11111)
        else $error("illegal utf-8 byte");

    // input side is idle-safe: ready never depends on an unknown after reset
    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown(s_tready))
        else $error("unknown ready");

endmodule

bind utf16_to_utf8_transcoder_top u2u8_checker u_checker (.*);

FILE: tb/sv/utf16_to_utf8_transcoder_top_test.sv
`timescale 1ns / 100ps

module utf16_to_utf8_transcoder_top_test;

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       string_end;
    } utf8_byte_t;

    typedef enum int {
        KIND_ASCII,
        KIND_TWO_BYTE,
        KIND_THREE_BYTE,
        KIND_PAIR,
        KIND_LONE_HIGH,
        KIND_LONE_LOW,
        KIND_ANY
    } unit_kind_t;

    class utf8_scoreboard;
        utf8_byte_t expected_bytes[$];
        logic [9:0] held_bits;
        bit         held_flag;
        int         mismatches;

        function new();
            held_bits  = '0;
            held_flag  = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void add_byte(ref logic [7:0] run_bytes[$], input logic [7:0] b);
            run_bytes.insert(run_bytes.size(), b);
        endfunction

        // three byte form of a bmp value, surrogates included
        function void add_three(ref logic [7:0] run_bytes[$], input logic [15:0] v);
            add_byte(run_bytes, u2u8_pkg::LEAD3 | {4'b0000, v[15:12]});
            add_byte(run_bytes, u2u8_pkg::CONT | {2'b00, v[11:6]});
            add_byte(run_bytes, u2u8_pkg::CONT | {2'b00, v[5:0]});
        endfunction

        function void note_unit(input logic [15:0] unit, input logic last);
            logic [7:0]  run_bytes[$];
            logic [20:0] code_point;
            bit          is_high;
            bit          is_low;
            int          n;
            utf8_byte_t  entry_byte;
            is_high = unit >= u2u8_pkg::HIGH_FIRST && unit < u2u8_pkg::LOW_FIRST;
            is_low  = unit >= u2u8_pkg::LOW_FIRST && unit <= u2u8_pkg::LOW_LAST;
            if (held_flag && is_low)
            begin
                code_point = {1'b0, held_bits, unit[9:0]} + u2u8_pkg::SUPP_BASE;
                add_byte(run_bytes, u2u8_pkg::LEAD4 | {5'b00000, code_point[20:18]});
                add_byte(run_bytes, u2u8_pkg::CONT | {2'b00, code_point[17:12]});
                add_byte(run_bytes, u2u8_pkg::CONT | {2'b00, code_point[11:6]});
                add_byte(run_bytes, u2u8_pkg::CONT | {2'b00, code_point[5:0]});
                held_flag = 1'b0;
                held_bits = '0;
            end
            else
            begin
                // unpaired high surrogate goes out before the new unit
                if (held_flag)
                begin
                    add_three(run_bytes, {u2u8_pkg::HIGH_PREFIX, held_bits});
                    held_flag = 1'b0;
                    held_bits = '0;
                end
                if (unit < u2u8_pkg::ONE_BYTE_LIMIT)
                    add_byte(run_bytes, unit[7:0]);
                else if (unit < u2u8_pkg::TWO_BYTE_LIMIT)
                begin
                    add_byte(run_bytes, u2u8_pkg::LEAD2 | {3'b000, unit[10:6]});
                    add_byte(run_bytes, u2u8_pkg::CONT | {2'b00, unit[5:0]});
                end
                else if (is_high && !last)
                begin
                    held_bits = unit[9:0];
                    held_flag = 1'b1;
                end
                else
                    add_three(run_bytes, unit);
            end
            n = run_bytes.size();
            for (int i = 0; i < n; i++)
            begin
                entry_byte.value      = run_bytes[i];
                entry_byte.run_last   = (i == n - 1);
                entry_byte.string_end = (i == n - 1) && last;
                expected_bytes.insert(expected_bytes.size(), entry_byte);
            end
        endfunction

        function void check_byte(input logic [7:0] value, input logic run_last,
                                 input logic string_end);
            utf8_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected byte %02h run_last %0b string_end %0b",
                             value, run_last, string_end);
                return;
            end
            want = expected_bytes[0];
            expected_bytes.delete(0);
            if (want.value !== value || want.run_last !== run_last ||
                want.string_end !== string_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("byte mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                             want.value, want.run_last, want.string_end,
                             value, run_last, string_end);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // code_unit
    logic        s_tlast = 1'b0;   // last_unit
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // out_byte
    logic        m_tlast;          // string_end
    logic        m_tuser;          // run_last

    utf8_scoreboard sb = new();
    bit             sender_steady = 1'b0;
    int             units_sent = 0;

    utf16_to_utf8_transcoder_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_unit(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tuser, m_tlast);
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic send_unit(input logic [15:0] unit, input logic last);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        units_sent++;
    endtask

    task automatic drain_bytes();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic [15:0] pick_non_low();
        logic [15:0] unit;
        do unit = 16'($urandom_range(0, 16'hFFFF));
        while (unit >= u2u8_pkg::LOW_FIRST && unit <= u2u8_pkg::LOW_LAST);
        return unit;
    endfunction

    task automatic send_random_units(input int count);
        unit_kind_t kind;
        int         roll;
        logic       last;
        int         stop_at;
        stop_at = units_sent + count;
        while (units_sent < stop_at)
        begin
            roll = $urandom_range(0, 99);
            last = ($urandom_range(0, 7) == 0);
            if (roll < 15)      kind = KIND_ASCII;
            else if (roll < 30) kind = KIND_TWO_BYTE;
            else if (roll < 45) kind = KIND_THREE_BYTE;
            else if (roll < 70) kind = KIND_PAIR;
            else if (roll < 80) kind = KIND_LONE_HIGH;
            else if (roll < 87) kind = KIND_LONE_LOW;
            else                kind = KIND_ANY;
            case (kind)
                KIND_ASCII:
                    send_unit(16'($urandom_range(0, 16'h007F)), last);
                KIND_TWO_BYTE:
                    send_unit(16'($urandom_range(16'h0080, 16'h07FF)), last);
                KIND_THREE_BYTE:
                    if ($urandom_range(0, 1))
                        send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), last);
                    else
                        send_unit(16'($urandom_range(16'hE000, 16'hFFFF)), last);
                KIND_PAIR:
                begin
                    send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                    send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), last);
                end
                KIND_LONE_HIGH:
                begin
                    send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                    send_unit(pick_non_low(), last);
                end
                KIND_LONE_LOW:
                    send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), last);
                default:
                    send_unit(16'($urandom_range(0, 16'hFFFF)), last);
            endcase
        end
    endtask

    // sink: ready runs with stalls, now and then a long stretch with no stall
    initial
    begin
        int gap;
        @(negedge clk);
        forever
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat (150) @(negedge clk);
            else
                repeat ($urandom_range(1, 16)) @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // plain ranges and their edges
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // surrogate pairs at both ends of the range
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // held high flushed by ascii, by another high, by a two byte unit, by a three byte unit
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hD801, 1'b0);
        send_unit(16'hD802, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'hDA55, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        // high surrogate at string end, alone and after a held one
        send_unit(16'hDBFF, 1'b1);
        send_unit(16'hDA00, 1'b0);
        send_unit(16'hDB00, 1'b1);
        // lone low, then a held high closed by a last three byte unit
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDA00, 1'b0);
        send_unit(16'h0800, 1'b1);

        drain_bytes();
        send_random_units(70);
        drain_bytes();
        sender_steady = 1'b1;
        send_random_units(35);
        sender_steady = 1'b0;
        send_random_units(39);
        // close the string so no surrogate stays held
        send_unit(16'h0021, 1'b1);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
